// File: rtl/pbt_pkg.sv
`timescale 1ns / 1ps

package pbt_pkg;

  localparam int SPEED_WIDTH = 16;
  localparam int POS_WIDTH = 32;

  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_PLAY = 3'd1;
  localparam logic [2:0] MODE_PAUSE = 3'd2;
  localparam logic [2:0] MODE_RESUME = 3'd3;
  localparam logic [2:0] MODE_STOP = 3'd4;
  localparam logic [2:0] MODE_GOTO = 3'd5;
  localparam logic [2:0] MODE_GOTO_PAUSE = 3'd6;
  localparam logic [2:0] MODE_GOTO_PLAY = 3'd7;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_LOOPED = 3'd1;
  localparam logic [2:0] EV_BOUNCED = 3'd2;
  localparam logic [2:0] EV_STOPPED = 3'd3;
  localparam logic [2:0] EV_STARTED = 3'd4;
  localparam logic [2:0] EV_PAUSED = 3'd5;
  localparam logic [2:0] EV_RESUMED = 3'd6;

  localparam logic [1:0] KIND_LOOP = 2'd1;
  localparam logic [1:0] KIND_BOUNCE = 2'd2;

  localparam logic [2:0] REG_DURATION = 3'd0;
  localparam logic [2:0] REG_SPEED = 3'd1;
  localparam logic [2:0] REG_REPLAY_KIND = 3'd2;
  localparam logic [2:0] REG_REVERSE = 3'd3;
  localparam logic [2:0] REG_DESTROY_ON_STOP = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_EDGE,
    S_REFL,
    S_CLAMP,
    S_DIV,
    S_EMIT
  } pbt_state_t;

  typedef struct packed {
    logic [SPEED_WIDTH-1:0] speed;
    logic [1:0]             replay_kind;
    logic                   reverse;
    logic                   destroy_on_stop;
  } pbt_ctl_t;

  typedef struct packed {
    logic [POS_WIDTH-1:0] position;
    logic [2:0]           event_code;
    logic                 destroyed;
    logic                 last;
  } pbt_res_t;

endpackage

// File: rtl/pbt_core.sv
`timescale 1ns / 1ps

module pbt_core
  import pbt_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  logic [2:0]            cmd_mode,
  input  logic [31:0]           cmd_delta_time,
  input  logic [31:0]           cmd_target_position,
  input  pbt_ctl_t              ctl,
  input  logic [TIME_WIDTH-1:0] duration,
  output logic                  res_valid,
  input  logic                  res_ready,
  output pbt_res_t              res
);

  localparam int AW = TIME_WIDTH + 17;
  localparam int CW = $clog2(TIME_WIDTH);
  localparam logic [CW-1:0] MUL_LAST = CW'(SPEED_WIDTH - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(TIME_WIDTH - 1);

  pbt_state_t state_r, state_nxt;
  logic [TIME_WIDTH-1:0]  cur_r, cur_nxt;
  logic                   bounce_r, bounce_nxt;
  logic                   playing_r, playing_nxt;
  logic                   destroyed_r, destroyed_nxt;
  logic signed [AW-1:0]   acc_r, acc_nxt;
  logic [TIME_WIDTH-1:0]  dt_r, dt_nxt;
  logic [TIME_WIDTH-1:0]  tgt_r, tgt_nxt;
  logic [SPEED_WIDTH-1:0] spd_r, spd_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [2:0]             ev_r, ev_nxt;
  logic [1:0]             nleft_r, nleft_nxt;
  logic [2:0]             mode_r, mode_nxt;

  logic signed [AW-1:0]   add_a, add_b, add_s;
  logic                   add_sub;
  logic signed [AW-1:0]   cur_ext, dur_ext, dt_ext, div_a;
  logic                   acc_gt_d, acc_neg;
  logic [TIME_WIDTH-1:0]  stop_pos;

  assign add_s = add_a + (add_sub ? ~add_b : add_b) + {{(AW-1){1'b0}}, add_sub};

  assign cur_ext  = $signed({17'd0, cur_r});
  assign dur_ext  = $signed({17'd0, duration});
  assign dt_ext   = $signed({17'd0, dt_r});
  assign div_a    = $signed({acc_r[AW-2:0], tgt_r[TIME_WIDTH-1]});
  assign acc_gt_d = acc_r > dur_ext;
  assign acc_neg  = acc_r[AW-1];
  assign stop_pos = ctl.reverse ? duration : '0;

  assign cmd_ready      = (state_r == S_IDLE);
  assign res_valid      = (state_r == S_EMIT);
  assign res.position   = POS_WIDTH'(cur_r);
  assign res.event_code = ev_r;
  assign res.destroyed  = destroyed_r;
  assign res.last       = (nleft_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      bounce_r    <= 1'b0;
      playing_r   <= 1'b0;
      destroyed_r <= 1'b0;
      nleft_r     <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      bounce_r    <= bounce_nxt;
      playing_r   <= playing_nxt;
      destroyed_r <= destroyed_nxt;
      nleft_r     <= nleft_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    dt_r   <= dt_nxt;
    tgt_r  <= tgt_nxt;
    spd_r  <= spd_nxt;
    cnt_r  <= cnt_nxt;
    ev_r   <= ev_nxt;
    mode_r <= mode_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    bounce_nxt    = bounce_r;
    playing_nxt   = playing_r;
    destroyed_nxt = destroyed_r;
    acc_nxt       = acc_r;
    dt_nxt        = dt_r;
    tgt_nxt       = tgt_r;
    spd_nxt       = spd_r;
    cnt_nxt       = cnt_r;
    ev_nxt        = ev_r;
    nleft_nxt     = nleft_r;
    mode_nxt      = mode_r;
    add_a         = '0;
    add_b         = '0;
    add_sub       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          mode_nxt  = cmd_mode;
          dt_nxt    = TIME_WIDTH'(cmd_delta_time);
          tgt_nxt   = TIME_WIDTH'(cmd_target_position);
          spd_nxt   = ctl.speed;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          nleft_nxt = 2'd0;
          case (cmd_mode)
            MODE_TICK: begin
              if (playing_r) begin
                state_nxt = S_MUL;
              end else begin
                ev_nxt    = EV_NONE;
                state_nxt = S_EMIT;
              end
            end
            MODE_PLAY: begin
              cur_nxt     = stop_pos;
              playing_nxt = 1'b1;
              ev_nxt      = EV_STOPPED;
              nleft_nxt   = 2'd2;
              state_nxt   = S_EMIT;
            end
            MODE_PAUSE: begin
              playing_nxt = 1'b0;
              ev_nxt      = EV_PAUSED;
              state_nxt   = S_EMIT;
            end
            MODE_RESUME: begin
              playing_nxt = 1'b1;
              ev_nxt      = EV_RESUMED;
              state_nxt   = S_EMIT;
            end
            MODE_STOP: begin
              playing_nxt = 1'b0;
              cur_nxt     = stop_pos;
              ev_nxt      = EV_STOPPED;
              state_nxt   = S_EMIT;
            end
            default: begin
              state_nxt = S_DIV;
            end
          endcase
        end
      end

      S_MUL: begin
        add_a   = $signed({acc_r[AW-2:0], 1'b0});
        add_b   = spd_r[SPEED_WIDTH-1] ? dt_ext : '0;
        acc_nxt = add_s;
        spd_nxt = {spd_r[SPEED_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = S_ADD;
        end
      end

      S_ADD: begin
        add_a     = cur_ext;
        add_b     = acc_r >>> 8;
        add_sub   = ctl.reverse ^ bounce_r;
        acc_nxt   = add_s;
        state_nxt = S_EDGE;
      end

      S_EDGE: begin
        ev_nxt    = EV_NONE;
        state_nxt = S_CLAMP;
        if (acc_gt_d || acc_neg) begin
          if (ctl.replay_kind == KIND_LOOP) begin
            ev_nxt = EV_LOOPED;
            if (acc_gt_d) begin
              add_a   = acc_r;
              add_b   = dur_ext;
              add_sub = 1'b1;
            end else begin
              add_a = dur_ext;
              add_b = acc_r;
            end
            acc_nxt = add_s;
          end else if (ctl.replay_kind == KIND_BOUNCE) begin
            ev_nxt     = EV_BOUNCED;
            bounce_nxt = !bounce_r;
            add_sub    = 1'b1;
            if (acc_gt_d) begin
              add_a     = acc_r;
              add_b     = dur_ext;
              state_nxt = S_REFL;
            end else begin
              add_a = '0;
              add_b = acc_r;
            end
            acc_nxt = add_s;
          end else begin
            ev_nxt        = EV_STOPPED;
            playing_nxt   = 1'b0;
            destroyed_nxt = destroyed_r | ctl.destroy_on_stop;
            acc_nxt       = acc_gt_d ? dur_ext : '0;
          end
        end
      end

      S_REFL: begin
        add_a     = dur_ext;
        add_b     = acc_r;
        add_sub   = 1'b1;
        acc_nxt   = add_s;
        state_nxt = S_CLAMP;
      end

      S_CLAMP: begin
        if (acc_neg) begin
          cur_nxt = '0;
        end else if (acc_gt_d) begin
          cur_nxt = duration;
        end else begin
          cur_nxt = acc_r[TIME_WIDTH-1:0];
        end
        state_nxt = S_EMIT;
      end

      S_DIV: begin
        add_a   = div_a;
        add_b   = dur_ext;
        add_sub = 1'b1;
        acc_nxt = add_s[AW-1] ? div_a : add_s;
        tgt_nxt = {tgt_r[TIME_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          cur_nxt = (duration == '0) ? '0 : acc_nxt[TIME_WIDTH-1:0];
          case (mode_r)
            MODE_GOTO_PAUSE: begin
              playing_nxt = 1'b0;
              ev_nxt      = EV_PAUSED;
            end
            MODE_GOTO_PLAY: begin
              playing_nxt = 1'b1;
              ev_nxt      = EV_RESUMED;
            end
            default: begin
              ev_nxt = EV_NONE;
            end
          endcase
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (res_ready) begin
          if (nleft_r == 2'd0) begin
            state_nxt = S_IDLE;
          end else begin
            nleft_nxt = nleft_r - 2'd1;
            ev_nxt    = (ev_r == EV_STOPPED) ? EV_RESUMED : EV_STARTED;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/playback_position_tracker_top.sv
`timescale 1ns / 1ps
// A tick that advances the position steps through S_MUL, S_ADD, S_EDGE, S_REFL (bounce past
// the end only), S_CLAMP and S_EMIT; the scaled step comes from a shift-and-add multiply on
// the shared adder. A goto runs the restoring modulo in S_DIV, one bit per cycle.
// Other commands go straight to their result; play gives three results.
// One command is in work at a time; in_tready rises again after its last result.
// Reset is synchronous and active low; it restores the register defaults and clears state.

module playback_position_tracker_top
  import pbt_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // delta_time[31:0], target_position[63:32]
  input  logic [2:0]  in_tuser,   // mode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // position[31:0], event_code[34:32], destroyed[35], zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data
);

  localparam logic [TIME_WIDTH-1:0] DURATION_RESET = TIME_WIDTH'(32'd65536);

  logic [TIME_WIDTH-1:0] duration_r;
  pbt_ctl_t              ctl_r;
  logic                  out_valid_r;
  pbt_res_t              out_res_r;
  logic                  res_valid;
  logic                  res_ready;
  pbt_res_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r            <= DURATION_RESET;
      ctl_r.speed           <= 16'd256;
      ctl_r.replay_kind     <= 2'd0;
      ctl_r.reverse         <= 1'b0;
      ctl_r.destroy_on_stop <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_DURATION:        duration_r <= TIME_WIDTH'(cfg_data);
        REG_SPEED:           ctl_r.speed <= cfg_data[15:0];
        REG_REPLAY_KIND:     ctl_r.replay_kind <= cfg_data[1:0];
        REG_REVERSE:         ctl_r.reverse <= cfg_data[0];
        REG_DESTROY_ON_STOP: ctl_r.destroy_on_stop <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  pbt_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (in_tvalid),
    .cmd_ready           (in_tready),
    .cmd_mode            (in_tuser),
    .cmd_delta_time      (in_tdata[31:0]),
    .cmd_target_position (in_tdata[63:32]),
    .ctl                 (ctl_r),
    .duration            (duration_r),
    .res_valid           (res_valid),
    .res_ready           (res_ready),
    .res                 (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.destroyed, out_res_r.event_code, out_res_r.position};
  assign out_tlast  = out_res_r.last;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("block still ready the cycle after taking a command");

  a_nonlast_only_play: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |->
      (out_tdata[34:32] == EV_STOPPED || out_tdata[34:32] == EV_RESUMED))
    else $error("non-final result with an event other than stopped or resumed");

  a_destroyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && $past(out_tvalid) && $past(out_tdata[35])) |-> out_tdata[35])
    else $error("destroyed flag cleared without reset");
`endif

endmodule

// File: dv/tb_playback_position_tracker_top.sv
`timescale 1ns / 1ps

module tb_playback_position_tracker_top;
  import pbt_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0] KIND_ONCE = 2'd0;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] delta_time;
    logic [31:0] target;
  } command_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  playback_position_tracker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the registers and the playback state.
  logic [31:0] dur_r = 32'd65536;
  logic [15:0] spd_r = 16'd256;
  logic [1:0]  kind_r = KIND_ONCE;
  logic        rev_r = 1'b0;
  logic        dos_r = 1'b0;
  logic [31:0] pos_q = '0;
  logic        bounce_bw = 1'b0;
  logic        playing = 1'b0;
  logic        dead = 1'b0;

  command_t   pending_cmds[$];
  pbt_res_t   expected_positions[$];
  command_t   cur_cmd;
  pbt_res_t   want_res;
  bit         item_pending = 1'b0;
  bit         in_taken = 1'b0;
  int         in_gap = 0;
  int         out_stall = 0;
  int         in_idle_pct = 0;
  int         out_idle_pct = 0;
  int         errors = 0;
  int         cycle_cnt = 0;
  int         cmds_sent = 0;
  int         results_seen = 0;
  int         settings_cnt = 0;
  int         ev_seen[8];

  function automatic void apply_setting(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      REG_DURATION: dur_r = val;
      REG_SPEED: spd_r = val[15:0];
      REG_REPLAY_KIND: kind_r = val[1:0];
      REG_REVERSE: rev_r = val[0];
      REG_DESTROY_ON_STOP: dos_r = val[0];
      default: ;
    endcase
  endfunction

  function automatic void emit_result(input logic [2:0] ev, input logic fin);
    expected_positions.push_back('{position: pos_q, event_code: ev, destroyed: dead,
                                   last: fin});
  endfunction

  function automatic void rewind();
    playing = 1'b0;
    pos_q = rev_r ? dur_r : 32'd0;
  endfunction

  function automatic void seek(input logic [31:0] target);
    pos_q = (dur_r == 32'd0) ? 32'd0 : target % dur_r;
  endfunction

  function automatic logic [2:0] advance(input logic [31:0] dt);
    longint unsigned step;
    longint d;
    longint np;
    logic [2:0] ev;
    ev = EV_NONE;
    if (!playing) return EV_NONE;
    step = (64'(dt) * 64'(spd_r)) >> 8;
    d = longint'({32'd0, dur_r});
    if (rev_r != bounce_bw) np = longint'({32'd0, pos_q}) - longint'(step);
    else np = longint'({32'd0, pos_q}) + longint'(step);
    if (np > d) begin
      if (kind_r == KIND_LOOP) begin
        np = np - d;
        ev = EV_LOOPED;
      end else if (kind_r == KIND_BOUNCE) begin
        np = d - (np - d);
        bounce_bw = !bounce_bw;
        ev = EV_BOUNCED;
      end else begin
        np = d;
        playing = 1'b0;
        if (dos_r) dead = 1'b1;
        ev = EV_STOPPED;
      end
    end else if (np < 0) begin
      if (kind_r == KIND_LOOP) begin
        np = d + np;
        ev = EV_LOOPED;
      end else if (kind_r == KIND_BOUNCE) begin
        np = -np;
        bounce_bw = !bounce_bw;
        ev = EV_BOUNCED;
      end else begin
        np = 0;
        playing = 1'b0;
        if (dos_r) dead = 1'b1;
        ev = EV_STOPPED;
      end
    end
    if (np < 0) np = 0;
    if (np > d) np = d;
    pos_q = np[31:0];
    return ev;
  endfunction

  function automatic void track_command(input command_t c);
    logic [2:0] ev;
    case (c.mode)
      MODE_TICK: begin
        ev = advance(c.delta_time);
        emit_result(ev, 1'b1);
      end
      MODE_PLAY: begin
        rewind();
        emit_result(EV_STOPPED, 1'b0);
        playing = 1'b1;
        emit_result(EV_RESUMED, 1'b0);
        emit_result(EV_STARTED, 1'b1);
      end
      MODE_PAUSE: begin
        playing = 1'b0;
        emit_result(EV_PAUSED, 1'b1);
      end
      MODE_RESUME: begin
        playing = 1'b1;
        emit_result(EV_RESUMED, 1'b1);
      end
      MODE_STOP: begin
        rewind();
        emit_result(EV_STOPPED, 1'b1);
      end
      MODE_GOTO: begin
        seek(c.target);
        emit_result(EV_NONE, 1'b1);
      end
      MODE_GOTO_PAUSE: begin
        seek(c.target);
        playing = 1'b0;
        emit_result(EV_PAUSED, 1'b1);
      end
      default: begin
        seek(c.target);
        playing = 1'b1;
        emit_result(EV_RESUMED, 1'b1);
      end
    endcase
  endfunction

  function automatic int pick_gap(input int pct);
    if (pct == 0 || $urandom_range(99) >= pct) return 0;
    if ($urandom_range(99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      track_command(cur_cmd);
      item_pending = 1'b0;
      in_taken = 1'b1;
      cmds_sent++;
    end
  end

  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        item_pending = 1'b1;
        in_tuser <= cur_cmd.mode;
        in_tdata <= {cur_cmd.target, cur_cmd.delta_time};
        in_tvalid <= 1'b1;
        in_gap = pick_gap(in_idle_pct);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_stall = pick_gap(out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      ev_seen[out_tdata[34:32]]++;
      if (expected_positions.size() == 0) begin
        $error("result with nothing expected: position %0h event %0d",
               out_tdata[31:0], out_tdata[34:32]);
        errors++;
      end else begin
        want_res = expected_positions.pop_front();
        if (out_tdata[31:0] !== want_res.position) begin
          $error("position: expected %0h, got %0h", want_res.position, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[34:32] !== want_res.event_code) begin
          $error("event_code: expected %0d, got %0d", want_res.event_code,
                 out_tdata[34:32]);
          errors++;
        end
        if (out_tdata[35] !== want_res.destroyed) begin
          $error("destroyed: expected %0b, got %0b", want_res.destroyed, out_tdata[35]);
          errors++;
        end
        if (out_tlast !== want_res.last) begin
          $error("last: expected %0b, got %0b", want_res.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_playback_position_tracker_top: FAIL");
      $finish;
    end
  end

  task automatic push_cmd(input logic [2:0] mode, input logic [31:0] dt,
                          input logic [31:0] target);
    pending_cmds.push_back('{mode: mode, delta_time: dt, target: target});
  endtask

  task automatic wait_idle(input int settle);
    do @(negedge clk);
    while (pending_cmds.size() != 0 || item_pending || expected_positions.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    apply_setting(idx, val);
    @(negedge clk);
  endtask

  task automatic set_cfg(input logic [31:0] dur, input logic [15:0] spd,
                         input logic [1:0] kind, input logic rev, input logic dos);
    wait_idle(8);
    cfg_write(REG_DURATION, dur);
    cfg_write(REG_SPEED, {16'd0, spd});
    cfg_write(REG_REPLAY_KIND, {30'd0, kind});
    cfg_write(REG_REVERSE, {31'd0, rev});
    cfg_write(REG_DESTROY_ON_STOP, {31'd0, dos});
    cfg_valid <= 1'b0;
    settings_cnt++;
  endtask

  function automatic logic [31:0] pick_dt();
    longint unsigned base;
    if (spd_r == 16'd0 || $urandom_range(19) == 0) return $urandom;
    base = (64'(dur_r) * 64'd256) / (64'(spd_r) * 64'($urandom_range(2, 10)));
    if (base == 0) base = 1;
    if (base > 64'hFFFF_FFFF) base = 64'hFFFF_FFFF;
    return $urandom_range(0, base[31:0]);
  endfunction

  function automatic logic [31:0] pick_target();
    if ($urandom_range(2) == 0) return $urandom;
    return $urandom_range(0, dur_r);
  endfunction

  task automatic random_phase(input int n_cmds);
    logic [31:0] dur;
    logic [15:0] spd;
    logic [1:0]  kind;
    int cnt;
    int steps;
    int r;
    case ($urandom_range(9))
      0: dur = 32'd1;
      1: dur = 32'hFFFF_FFFF;
      2, 3: dur = $urandom_range(1, 32'hFFFF_FFFF);
      default: dur = $urandom_range(32'h100, 32'h8_0000);
    endcase
    case ($urandom_range(7))
      0: spd = 16'd0;
      1: spd = 16'hFFFF;
      2: spd = 16'd256;
      default: spd = $urandom_range(1, 16'hFFFF);
    endcase
    kind = ($urandom_range(9) == 0) ? KIND_SPARE : 2'($urandom_range(2));
    set_cfg(dur, spd, kind, 1'($urandom_range(1)), 1'($urandom_range(3) == 0));
    in_idle_pct = ($urandom_range(3) == 0) ? 0 : 10 * $urandom_range(1, 6);
    out_idle_pct = ($urandom_range(3) == 0) ? 0 : 10 * $urandom_range(1, 6);
    cnt = 0;
    while (cnt < n_cmds) begin
      if ($urandom_range(99) < 15) begin
        push_cmd(3'($urandom_range(7)), $urandom, $urandom);
        cnt++;
      end else begin
        push_cmd(MODE_PLAY, $urandom, $urandom);
        cnt++;
        steps = $urandom_range(3, 10);
        repeat (steps) begin
          r = $urandom_range(99);
          if (r < 75) push_cmd(MODE_TICK, pick_dt(), $urandom);
          else if (r < 80) push_cmd(MODE_PAUSE, $urandom, $urandom);
          else if (r < 86) push_cmd(MODE_RESUME, $urandom, $urandom);
          else if (r < 89) push_cmd(MODE_STOP, $urandom, $urandom);
          else if (r < 93) push_cmd(MODE_GOTO, $urandom, pick_target());
          else if (r < 96) push_cmd(MODE_GOTO_PAUSE, $urandom, pick_target());
          else push_cmd(MODE_GOTO_PLAY, $urandom, pick_target());
          cnt++;
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_idle_pct = 30;
    out_idle_pct = 30;
    push_cmd(MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(MODE_PLAY, 32'd0, 32'd0);
    push_cmd(MODE_TICK, 32'h8000, 32'd0);
    push_cmd(MODE_TICK, 32'h8000, 32'd0);
    push_cmd(MODE_TICK, 32'd1, 32'd0);
    push_cmd(MODE_RESUME, 32'd0, 32'd0);
    push_cmd(MODE_PAUSE, 32'd0, 32'd0);
    push_cmd(MODE_STOP, 32'd0, 32'd0);
    push_cmd(MODE_GOTO, 32'd0, 32'hFFFF_FFFF);
    push_cmd(MODE_GOTO_PAUSE, 32'hFFFF_FFFF, 32'd0);
    push_cmd(MODE_GOTO_PLAY, 32'd0, 32'h1_8000);
    push_cmd(MODE_TICK, 32'hFFFF_FFFF, 32'd0);

    set_cfg(32'h1_0000, 16'd256, KIND_LOOP, 1'b0, 1'b1);
    push_cmd(MODE_PLAY, 32'd0, 32'd0);
    push_cmd(MODE_TICK, 32'h3_0000, 32'd0);
    push_cmd(MODE_TICK, 32'h4000, 32'd0);

    set_cfg(32'h1_0000, 16'hFFFF, KIND_BOUNCE, 1'b1, 1'b1);
    push_cmd(MODE_PLAY, 32'd0, 32'd0);
    push_cmd(MODE_TICK, 32'h80, 32'd0);
    push_cmd(MODE_TICK, 32'h100, 32'd0);

    set_cfg(32'h2_0000, 16'd512, KIND_SPARE, 1'b0, 1'b1);
    push_cmd(MODE_PLAY, 32'd0, 32'd0);
    push_cmd(MODE_TICK, 32'h1_0000, 32'd0);
    push_cmd(MODE_TICK, 32'd1, 32'd0);
    push_cmd(MODE_STOP, 32'd0, 32'd0);

    set_cfg(32'd0, 16'd256, KIND_LOOP, 1'b0, 1'b0);
    push_cmd(MODE_GOTO, 32'd0, 32'd12345);
    push_cmd(MODE_GOTO_PLAY, 32'd0, 32'hFFFF_FFFF);
    push_cmd(MODE_TICK, 32'd1, 32'd0);

    set_cfg(32'hFFFF_FFFF, 16'hFFFF, KIND_LOOP, 1'b1, 1'b0);
    push_cmd(MODE_PLAY, 32'd0, 32'd0);
    push_cmd(MODE_TICK, 32'hFFFF_FFFF, 32'd0);

    repeat (8) random_phase(55);

    wait_idle(60);
    $display("Sent %0d commands under %0d register settings and checked %0d results.",
             cmds_sent, settings_cnt, results_seen);
    $display("Events seen: %0d looped, %0d bounced, %0d stopped, %0d paused.",
             ev_seen[EV_LOOPED], ev_seen[EV_BOUNCED], ev_seen[EV_STOPPED],
             ev_seen[EV_PAUSED]);
    if (errors == 0) begin
      $display("tb_playback_position_tracker_top: PASS");
    end else begin
      $display("tb_playback_position_tracker_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pbt_pkg.sv
rtl/pbt_core.sv
rtl/playback_position_tracker_top.sv
dv/tb_playback_position_tracker_top.sv
